### src/pidfd_pkg.sv
`default_nettype none

package pidfd_pkg;

    localparam int DATA_W = 32;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int TERM_W = 48;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LIMIT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_SMOOTH = 3'd7;

    localparam logic signed [MUL_W-1:0] ONE_Q16 = 33'sd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_NEW,
        ST_T_OLD,
        ST_T_SUM,
        ST_T_RND,
        ST_ERR,
        ST_P_MUL,
        ST_I_MUL,
        ST_D_MUL,
        ST_INTEG,
        ST_DB_NEW,
        ST_DB_OLD,
        ST_DB_SUM,
        ST_DB_RND,
        ST_SUM,
        ST_CLAMP
    } pidfd_state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 67'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -67'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Divide by 2^16, rounding to nearest with ties toward positive infinity.
    function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + 67'sd32768;
        return t >>> 16;
    endfunction

endpackage

`default_nettype wire

### src/pidfd_mul.sv
`default_nettype none

module pidfd_mul (
    input  wire logic                                 aclk,
    input  wire logic signed [pidfd_pkg::MUL_W-1:0]   mul_a,
    input  wire logic signed [pidfd_pkg::MUL_W-1:0]   mul_b,
    output logic signed [pidfd_pkg::PROD_W-1:0]       prod
);

    logic signed [pidfd_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### src/pid_filtered_derivative.sv
// PID controller with a smoothed target and a low-pass filtered derivative, Q16.16.
// The input channel (s_valid, s_ready, s_measured, s_setpoint) takes one sample per
// control tick; the result channel (m_valid, m_ready, m_drive) returns one drive value
// per sample, in order.
// A sample is accepted in the idle state and then runs fifteen sequencer steps that
// reuse a single registered 33 by 33 bit multiplier for the seven products of the loop.
// s_ready is high only while the sequencer is idle, so a new sample is not accepted
// until the sequencer has finished with the previous one.
// The result sits in an output register; the next sample is accepted and worked on
// while it waits. If the receiver still holds off when the next result is due, the
// sequencer pauses at its last step until the output register is free.
// Gains, limits and weights are written through cfg_wr_en, cfg_index and cfg_data;
// the user must do so only while the block is idle, which the block does not enforce.
// Reset (aresetn low, synchronous) clears the filter, error and integral state to zero,
// loads the register defaults and empties the output register.
`default_nettype none

module pid_filtered_derivative #(
    parameter int TARGET_SMOOTH = 52429
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      cfg_wr_en,
    input  wire logic [pidfd_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  wire logic [pidfd_pkg::DATA_W-1:0]              cfg_data,
    input  wire logic                                      s_valid,
    output logic                                           s_ready,
    input  wire logic signed [pidfd_pkg::DATA_W-1:0]       s_measured,
    input  wire logic signed [pidfd_pkg::DATA_W-1:0]       s_setpoint,
    output logic                                           m_valid,
    input  wire logic                                      m_ready,
    output logic signed [pidfd_pkg::DATA_W-1:0]            m_drive
);

    localparam int TS_CLAMP = (TARGET_SMOOTH > 65536) ? 65536 :
                              ((TARGET_SMOOTH < 0) ? 0 : TARGET_SMOOTH);
    localparam logic signed [pidfd_pkg::MUL_W-1:0] TS_NEW = 33'(TS_CLAMP);
    localparam logic signed [pidfd_pkg::MUL_W-1:0] TS_OLD = 33'(65536 - TS_CLAMP);

    localparam int DW = pidfd_pkg::DATA_W;
    localparam int MW = pidfd_pkg::MUL_W;
    localparam int PW = pidfd_pkg::PROD_W;
    localparam int AW = pidfd_pkg::ACC_W;
    localparam int TW = pidfd_pkg::TERM_W;

    pidfd_pkg::pidfd_state_t state_reg, state_next;

    logic signed [DW-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic        [DW-2:0] integ_limit_reg, dead_zone_reg;
    logic signed [DW-1:0] out_max_reg, out_min_reg;
    logic        [16:0]   deriv_smooth_reg;

    logic signed [DW-1:0] smoothed_reg, smoothed_next;
    logic signed [DW-1:0] prev_err_reg, prev_err_next;
    logic signed [DW-1:0] integral_reg, integral_next;
    logic signed [DW-1:0] prev_deriv_reg, prev_deriv_next;

    logic signed [DW-1:0] meas_reg, meas_next;
    logic signed [DW-1:0] sp_reg, sp_next;
    logic signed [DW-1:0] err_reg, err_next;
    logic signed [DW:0]   diff_reg, diff_next;
    logic signed [TW-1:0] pterm_reg, pterm_next;
    logic signed [TW-1:0] iterm_reg, iterm_next;
    logic signed [DW-1:0] dcur_reg, dcur_next;
    logic signed [DW-1:0] sum_reg, sum_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [DW-1:0] drive_reg, drive_next;
    logic                 m_valid_reg, m_valid_next;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] prod_ext;
    logic signed [AW-1:0] rnd_prod;
    logic signed [MW-1:0] wd;
    logic                 out_free;

    logic signed [AW-1:0] integ_sum;
    logic signed [AW-1:0] limit_ext;
    logic signed [DW-1:0] clamp_hi, clamp_lo;
    logic        [DW:0]   mag;

    pidfd_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign prod_ext = AW'(prod);
    assign rnd_prod = pidfd_pkg::rnd16(prod_ext);
    assign wd       = (deriv_smooth_reg > 17'd65536) ? pidfd_pkg::ONE_Q16
                                                     : MW'(deriv_smooth_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == pidfd_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_drive = drive_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pidfd_pkg::ST_IDLE:   if (s_valid) state_next = pidfd_pkg::ST_T_NEW;
            pidfd_pkg::ST_T_NEW:  state_next = pidfd_pkg::ST_T_OLD;
            pidfd_pkg::ST_T_OLD:  state_next = pidfd_pkg::ST_T_SUM;
            pidfd_pkg::ST_T_SUM:  state_next = pidfd_pkg::ST_T_RND;
            pidfd_pkg::ST_T_RND:  state_next = pidfd_pkg::ST_ERR;
            pidfd_pkg::ST_ERR:    state_next = pidfd_pkg::ST_P_MUL;
            pidfd_pkg::ST_P_MUL:  state_next = pidfd_pkg::ST_I_MUL;
            pidfd_pkg::ST_I_MUL:  state_next = pidfd_pkg::ST_D_MUL;
            pidfd_pkg::ST_D_MUL:  state_next = pidfd_pkg::ST_INTEG;
            pidfd_pkg::ST_INTEG:  state_next = pidfd_pkg::ST_DB_NEW;
            pidfd_pkg::ST_DB_NEW: state_next = pidfd_pkg::ST_DB_OLD;
            pidfd_pkg::ST_DB_OLD: state_next = pidfd_pkg::ST_DB_SUM;
            pidfd_pkg::ST_DB_SUM: state_next = pidfd_pkg::ST_DB_RND;
            pidfd_pkg::ST_DB_RND: state_next = pidfd_pkg::ST_SUM;
            pidfd_pkg::ST_SUM:    state_next = pidfd_pkg::ST_CLAMP;
            pidfd_pkg::ST_CLAMP:  if (out_free) state_next = pidfd_pkg::ST_IDLE;
            default:              state_next = pidfd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a           = '0;
        mul_b           = '0;
        smoothed_next   = smoothed_reg;
        prev_err_next   = prev_err_reg;
        integral_next   = integral_reg;
        prev_deriv_next = prev_deriv_reg;
        meas_next       = meas_reg;
        sp_next         = sp_reg;
        err_next        = err_reg;
        diff_next       = diff_reg;
        pterm_next      = pterm_reg;
        iterm_next      = iterm_reg;
        dcur_next       = dcur_reg;
        sum_next        = sum_reg;
        acc_next        = acc_reg;
        drive_next      = drive_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        integ_sum = AW'(integral_reg) + AW'(iterm_reg);
        limit_ext = AW'(integ_limit_reg);
        clamp_hi  = (sum_reg > out_max_reg) ? out_max_reg : sum_reg;
        clamp_lo  = (clamp_hi < out_min_reg) ? out_min_reg : clamp_hi;
        mag       = clamp_lo[DW-1] ? (DW+1)'(-(DW+1)'(clamp_lo)) : (DW+1)'(clamp_lo);

        case (state_reg)
            pidfd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    meas_next = s_measured;
                    sp_next   = s_setpoint;
                end
            end
            pidfd_pkg::ST_T_NEW: begin
                mul_a = TS_NEW;
                mul_b = MW'(sp_reg);
            end
            pidfd_pkg::ST_T_OLD: begin
                acc_next = prod_ext;
                mul_a    = TS_OLD;
                mul_b    = MW'(smoothed_reg);
            end
            pidfd_pkg::ST_T_SUM: begin
                acc_next = acc_reg + prod_ext;
            end
            pidfd_pkg::ST_T_RND: begin
                smoothed_next = pidfd_pkg::sat32(pidfd_pkg::rnd16(acc_reg));
            end
            pidfd_pkg::ST_ERR: begin
                err_next = pidfd_pkg::sat32(AW'(smoothed_reg) - AW'(meas_reg));
            end
            pidfd_pkg::ST_P_MUL: begin
                mul_a     = MW'(prop_gain_reg);
                mul_b     = MW'(err_reg);
                diff_next = (DW+1)'(err_reg) - (DW+1)'(prev_err_reg);
            end
            pidfd_pkg::ST_I_MUL: begin
                pterm_next = rnd_prod[TW-1:0];
                mul_a      = MW'(err_reg);
                mul_b      = MW'(integ_gain_reg);
            end
            pidfd_pkg::ST_D_MUL: begin
                iterm_next = rnd_prod[TW-1:0];
                mul_a      = MW'(deriv_gain_reg);
                mul_b      = diff_reg;
            end
            pidfd_pkg::ST_INTEG: begin
                if (integ_sum > limit_ext) begin
                    integral_next = limit_ext[DW-1:0];
                end else if (integ_sum < -limit_ext) begin
                    integral_next = DW'(-limit_ext);
                end else begin
                    integral_next = integ_sum[DW-1:0];
                end
                dcur_next = pidfd_pkg::sat32(rnd_prod);
            end
            pidfd_pkg::ST_DB_NEW: begin
                mul_a = wd;
                mul_b = MW'(dcur_reg);
            end
            pidfd_pkg::ST_DB_OLD: begin
                acc_next = prod_ext;
                mul_a    = pidfd_pkg::ONE_Q16 - wd;
                mul_b    = MW'(prev_deriv_reg);
            end
            pidfd_pkg::ST_DB_SUM: begin
                acc_next = acc_reg + prod_ext;
            end
            pidfd_pkg::ST_DB_RND: begin
                prev_deriv_next = pidfd_pkg::sat32(pidfd_pkg::rnd16(acc_reg));
                prev_err_next   = err_reg;
            end
            pidfd_pkg::ST_SUM: begin
                sum_next = pidfd_pkg::sat32(AW'(pterm_reg) + AW'(integral_reg)
                                            + AW'(prev_deriv_reg));
            end
            pidfd_pkg::ST_CLAMP: begin
                if (out_free) begin
                    drive_next   = (mag < (DW+1)'(dead_zone_reg)) ? '0 : clamp_lo;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= pidfd_pkg::ST_IDLE;
            m_valid_reg      <= 1'b0;
            prop_gain_reg    <= 32'sd65536;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            integ_limit_reg  <= 31'd655360;
            out_max_reg      <= 32'sh7FFFFFFF;
            out_min_reg      <= 32'sh80000000;
            dead_zone_reg    <= '0;
            deriv_smooth_reg <= '0;
            smoothed_reg     <= '0;
            prev_err_reg     <= '0;
            integral_reg     <= '0;
            prev_deriv_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            smoothed_reg   <= smoothed_next;
            prev_err_reg   <= prev_err_next;
            integral_reg   <= integral_next;
            prev_deriv_reg <= prev_deriv_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    pidfd_pkg::REG_PROP_GAIN:    prop_gain_reg    <= cfg_data;
                    pidfd_pkg::REG_INTEG_GAIN:   integ_gain_reg   <= cfg_data;
                    pidfd_pkg::REG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data;
                    pidfd_pkg::REG_INTEG_LIMIT:  integ_limit_reg  <= cfg_data[DW-2:0];
                    pidfd_pkg::REG_OUT_MAX:      out_max_reg      <= cfg_data;
                    pidfd_pkg::REG_OUT_MIN:      out_min_reg      <= cfg_data;
                    pidfd_pkg::REG_DEAD_ZONE:    dead_zone_reg    <= cfg_data[DW-2:0];
                    pidfd_pkg::REG_DERIV_SMOOTH: deriv_smooth_reg <= cfg_data[16:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        meas_reg  <= meas_next;
        sp_reg    <= sp_next;
        err_reg   <= err_next;
        diff_reg  <= diff_next;
        pterm_reg <= pterm_next;
        iterm_reg <= iterm_next;
        dcur_reg  <= dcur_next;
        sum_reg   <= sum_next;
        acc_reg   <= acc_next;
        drive_reg <= drive_next;
    end

endmodule

`default_nettype wire
